### rtl/ttcb_pkg.sv
package ttcb_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CMP_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd3;

  localparam logic [31:0] RESET_FG   = 32'h00FF_FFFF;
  localparam logic [31:0] RESET_BG   = 32'h0000_0000;
  localparam logic [7:0]  RESET_COLS = 8'd80;
  localparam logic [6:0]  RESET_ROWS = 7'd25;

  localparam logic [7:0] BLANK_CODE = 8'd32;
  localparam logic [7:0] NL_CODE    = 8'd10;
  localparam logic [7:0] BS_CODE    = 8'd8;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd127;

  typedef enum logic [2:0] {
    ACT_PUT    = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_SETCUR = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] fg;
    logic [31:0] bg;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  char_code;
    logic [7:0]  column;
    logic [7:0]  line;
    logic [31:0] cell_fg;
    logic [31:0] cell_bg;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_line;
    logic        scrolled;
    logic        in_range;
    logic [7:0]  read_code;
    logic [31:0] read_fg;
    logic [31:0] read_bg;
  } out_item_t;

endpackage

### rtl/ttcb_stream_if.sv
interface ttcb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/text_terminal_cell_buffer.sv
// text terminal cell buffer: character cells (code, fg, bg) plus a cursor
// in_chan takes one action per transfer (put char, write cell, set cursor,
// clear, read cell); out_chan returns exactly one result per action
// cfg_we/cfg_index/cfg_wdata write text_fg, text_bg, cols_in_use, rows_in_use
// put char without scroll, write cell, set cursor: taken in S_IDLE, result
// loaded into the output register from S_DONE; read cell passes S_RDATA
// first for the registered ram read; newline that scrolls: S_SCROLL moves the
// rows up, one cell moved per cycle through the single cell ram, S_SDRAIN
// writes back the last cell, then S_BLANK blanks the new bottom row
// clear: S_FILL writes every ram entry, one ram entry written per cycle
// reset: a clearing pass fills every cell with a space in the reset colors;
// in_chan is not ready during the pass, config writes are taken as usual
// one item at a time; a new item is taken while the previous result still
// sits in the output register, and a finished result waits there for as long
// as the receiver stalls
module text_terminal_cell_buffer #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ttcb_stream_if.sink                     in_chan,
  ttcb_stream_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [ttcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttcb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CCW   = $clog2(MAX_COLS);
  localparam int RRW   = $clog2(MAX_ROWS);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = ttcb_pkg::CMP_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDATA  = 7'b0000010,
    S_SCROLL = 7'b0000100,
    S_SDRAIN = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]    text_fg_r, text_bg_r;
  logic [7:0]     cols_r;
  logic [6:0]     rows_r;

  logic [CCW-1:0] cur_col_r, cur_col_nxt;
  logic [RRW-1:0] cur_row_r, cur_row_nxt;
  logic [CCW-1:0] sc_col_r, sc_col_nxt;
  logic [RRW-1:0] sc_row_r, sc_row_nxt;
  logic           cp_wv_r, cp_wv_nxt;
  logic [AW-1:0]  cp_waddr_r, cp_waddr_nxt;
  logic [AW-1:0]  fill_r, fill_nxt;
  logic           init_r, init_nxt;

  logic           res_scrolled_r, res_scrolled_nxt;
  logic           res_in_range_r, res_in_range_nxt;
  ttcb_pkg::cell_t res_cell_r, res_cell_nxt;

  logic               out_valid_r, out_valid_nxt;
  ttcb_pkg::out_item_t out_data_r, out_data_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  ttcb_pkg::cell_t             ram_wdata, ram_rdata;
  logic [ttcb_pkg::CELL_W-1:0] ram_rdata_raw;

  logic [ECW-1:0] eff_cols;
  logic [RCW-1:0] eff_rows;
  logic [CW-1:0]  cols9, rows9;
  logic [CCW-1:0] cc;
  logic [RRW-1:0] cr;
  logic           in_screen;
  logic           do_nl;
  logic           out_free;
  logic           last_col;
  ttcb_pkg::cell_t blank_cell;
  ttcb_pkg::in_item_t item;

  function automatic logic [AW-1:0] cell_addr(input logic [RRW-1:0] r,
                                              input logic [CCW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  ttcb_ram #(
    .WIDTH (ttcb_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;
  assign item = in_chan.data;

  // effective screen size
  always_comb begin
    if (cols_r == 8'd0) begin
      eff_cols = ECW'(1);
    end else if (CW'(cols_r) > CW'(MAX_COLS)) begin
      eff_cols = ECW'(MAX_COLS);
    end else begin
      eff_cols = ECW'(cols_r);
    end
    if (rows_r == 7'd0) begin
      eff_rows = RCW'(1);
    end else if (CW'(rows_r) > CW'(MAX_ROWS)) begin
      eff_rows = RCW'(MAX_ROWS);
    end else begin
      eff_rows = RCW'(rows_r);
    end
  end

  assign cols9 = CW'(eff_cols);
  assign rows9 = CW'(eff_rows);
  assign cc = (CW'(cur_col_r) >= cols9) ? CCW'(cols9 - CW'(1)) : cur_col_r;
  assign cr = (CW'(cur_row_r) >= rows9) ? RRW'(rows9 - CW'(1)) : cur_row_r;
  assign in_screen = (CW'(item.column) < cols9) && (CW'(item.line) < rows9);
  assign last_col = (CW'(sc_col_r) == cols9 - CW'(1));
  assign out_free = !out_valid_r || out_chan.ready;

  assign blank_cell.code = ttcb_pkg::BLANK_CODE;
  assign blank_cell.fg   = init_r ? ttcb_pkg::RESET_FG : text_fg_r;
  assign blank_cell.bg   = init_r ? ttcb_pkg::RESET_BG : text_bg_r;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    state_nxt        = state_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    sc_col_nxt       = sc_col_r;
    sc_row_nxt       = sc_row_r;
    cp_wv_nxt        = cp_wv_r;
    cp_waddr_nxt     = cp_waddr_r;
    fill_nxt         = fill_r;
    init_nxt         = init_r;
    res_scrolled_nxt = res_scrolled_r;
    res_in_range_nxt = res_in_range_r;
    res_cell_nxt     = res_cell_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_data_nxt     = out_data_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = blank_cell;
    ram_raddr        = '0;
    do_nl            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // keep the cursor inside the screen after a resize
        cur_col_nxt = cc;
        cur_row_nxt = cr;
        if (in_chan.valid) begin
          state_nxt        = S_DONE;
          res_scrolled_nxt = 1'b0;
          res_in_range_nxt = 1'b0;
          res_cell_nxt     = '0;
          unique case (item.action)
            ttcb_pkg::ACT_PUT: begin
              res_in_range_nxt = 1'b1;
              if (item.char_code == ttcb_pkg::NL_CODE) begin
                do_nl = 1'b1;
              end else if (item.char_code == ttcb_pkg::BS_CODE) begin
                if (cc != '0) begin
                  cur_col_nxt = cc - CCW'(1);
                  ram_we      = 1'b1;
                  ram_waddr   = cell_addr(cr, cc - CCW'(1));
                  ram_wdata   = blank_cell;
                end
              end else if (item.char_code >= ttcb_pkg::PRINT_LO &&
                           item.char_code <= ttcb_pkg::PRINT_HI) begin
                ram_we         = 1'b1;
                ram_waddr      = cell_addr(cr, cc);
                ram_wdata.code = item.char_code;
                ram_wdata.fg   = text_fg_r;
                ram_wdata.bg   = text_bg_r;
                if (CW'(cc) + CW'(1) >= cols9) begin
                  do_nl = 1'b1;
                end else begin
                  cur_col_nxt = cc + CCW'(1);
                end
              end
            end
            ttcb_pkg::ACT_WRITE: begin
              res_in_range_nxt = in_screen;
              if (in_screen) begin
                ram_we         = 1'b1;
                ram_waddr      = cell_addr(RRW'(item.line), CCW'(item.column));
                ram_wdata.code = item.char_code;
                ram_wdata.fg   = item.cell_fg;
                ram_wdata.bg   = item.cell_bg;
              end
            end
            ttcb_pkg::ACT_SETCUR: begin
              res_in_range_nxt = in_screen;
              cur_col_nxt = (CW'(item.column) >= cols9) ? CCW'(cols9 - CW'(1))
                                                        : CCW'(item.column);
              cur_row_nxt = (CW'(item.line) >= rows9) ? RRW'(rows9 - CW'(1))
                                                      : RRW'(item.line);
            end
            ttcb_pkg::ACT_CLEAR: begin
              state_nxt   = S_FILL;
              fill_nxt    = '0;
              cur_col_nxt = '0;
              cur_row_nxt = '0;
            end
            ttcb_pkg::ACT_READ: begin
              if (in_screen) begin
                res_in_range_nxt = 1'b1;
                ram_raddr        = cell_addr(RRW'(item.line), CCW'(item.column));
                state_nxt        = S_RDATA;
              end
            end
            default: begin
            end
          endcase
          // newline, with scroll on the bottom row of a screen of more than one row
          if (do_nl) begin
            cur_col_nxt = '0;
            if (CW'(cr) + CW'(1) < rows9) begin
              cur_row_nxt = cr + RRW'(1);
            end else if (rows9 > CW'(1)) begin
              res_scrolled_nxt = 1'b1;
              state_nxt        = S_SCROLL;
              sc_col_nxt       = '0;
              sc_row_nxt       = '0;
              cp_wv_nxt        = 1'b0;
            end
          end
        end
      end
      S_RDATA: begin
        res_cell_nxt = ram_rdata;
        state_nxt    = S_DONE;
      end
      S_SCROLL: begin
        // read one row below, write back the cell read the cycle before
        ram_raddr    = cell_addr(sc_row_r + RRW'(1), sc_col_r);
        ram_we       = cp_wv_r;
        ram_waddr    = cp_waddr_r;
        ram_wdata    = ram_rdata;
        cp_wv_nxt    = 1'b1;
        cp_waddr_nxt = cell_addr(sc_row_r, sc_col_r);
        if (last_col) begin
          sc_col_nxt = '0;
          if (CW'(sc_row_r) == rows9 - CW'(2)) begin
            state_nxt = S_SDRAIN;
          end else begin
            sc_row_nxt = sc_row_r + RRW'(1);
          end
        end else begin
          sc_col_nxt = sc_col_r + CCW'(1);
        end
      end
      S_SDRAIN: begin
        ram_we     = cp_wv_r;
        ram_waddr  = cp_waddr_r;
        ram_wdata  = ram_rdata;
        cp_wv_nxt  = 1'b0;
        sc_col_nxt = '0;
        state_nxt  = S_BLANK;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(RRW'(rows9 - CW'(1)), sc_col_r);
        ram_wdata = blank_cell;
        if (last_col) begin
          state_nxt = S_DONE;
        end else begin
          sc_col_nxt = sc_col_r + CCW'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_r;
        ram_wdata = blank_cell;
        if (fill_r == AW'(CELLS - 1)) begin
          state_nxt = init_r ? S_IDLE : S_DONE;
          init_nxt  = 1'b0;
        end else begin
          fill_nxt = fill_r + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cursor_column = 7'(cur_col_r);
          out_data_nxt.cursor_line   = 6'(cur_row_r);
          out_data_nxt.scrolled      = res_scrolled_r;
          out_data_nxt.in_range      = res_in_range_r;
          out_data_nxt.read_code     = res_cell_r.code;
          out_data_nxt.read_fg       = res_cell_r.fg;
          out_data_nxt.read_bg       = res_cell_r.bg;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      init_r      <= 1'b1;
      fill_r      <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      sc_col_r    <= '0;
      sc_row_r    <= '0;
      cp_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      fill_r      <= fill_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      sc_col_r    <= sc_col_nxt;
      sc_row_r    <= sc_row_nxt;
      cp_wv_r     <= cp_wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_waddr_r     <= cp_waddr_nxt;
    res_scrolled_r <= res_scrolled_nxt;
    res_in_range_r <= res_in_range_nxt;
    res_cell_r     <= res_cell_nxt;
    out_data_r     <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_fg_r <= ttcb_pkg::RESET_FG;
      text_bg_r <= ttcb_pkg::RESET_BG;
      cols_r    <= ttcb_pkg::RESET_COLS;
      rows_r    <= ttcb_pkg::RESET_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttcb_pkg::REG_TEXT_FG: text_fg_r <= cfg_wdata;
        ttcb_pkg::REG_TEXT_BG: text_bg_r <= cfg_wdata;
        ttcb_pkg::REG_COLS:    cols_r    <= cfg_wdata[7:0];
        ttcb_pkg::REG_ROWS:    rows_r    <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end
endmodule

### rtl/ttcb_ram.sv
module ttcb_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### tb/ttcb_reply_checker.sv
module ttcb_reply_checker
  import ttcb_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    replies_waiting,
  output int                    replies_seen,
  output int                    scroll_count
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;

  logic [7:0]  code_mem [CELLS];
  logic [31:0] fg_mem [CELLS];
  logic [31:0] bg_mem [CELLS];
  int unsigned cur_x;
  int unsigned cur_y;
  logic [31:0] pen_fg;
  logic [31:0] pen_bg;
  logic [7:0]  cols_reg;
  logic [6:0]  rows_reg;
  out_item_t   awaited_replies[$];
  int          n_fail = 0;
  int          n_waiting = 0;
  int          n_seen = 0;
  int          n_scroll = 0;

  assign fail_count      = n_fail;
  assign replies_waiting = n_waiting;
  assign replies_seen    = n_seen;
  assign scroll_count    = n_scroll;

  function automatic int unsigned screen_cols();
    if (cols_reg == 0) return 1;
    return (32'(cols_reg) > MAX_COLS) ? MAX_COLS : 32'(cols_reg);
  endfunction

  function automatic int unsigned screen_rows();
    if (rows_reg == 0) return 1;
    return (32'(rows_reg) > MAX_ROWS) ? MAX_ROWS : 32'(rows_reg);
  endfunction

  function automatic void put_cell(int unsigned x, int unsigned y, logic [7:0] code,
                                   logic [31:0] fg, logic [31:0] bg);
    int unsigned idx;
    idx = y * MAX_COLS + x;
    if (x >= MAX_COLS || idx >= CELLS) return;
    code_mem[idx] = code;
    fg_mem[idx]   = fg;
    bg_mem[idx]   = bg;
  endfunction

  function automatic void blank_everything();
    for (int i = 0; i < CELLS; i++) begin
      code_mem[i] = BLANK_CODE;
      fg_mem[i]   = pen_fg;
      bg_mem[i]   = pen_bg;
    end
  endfunction

  function automatic void fit_cursor();
    if (cur_x >= screen_cols()) cur_x = screen_cols() - 1;
    if (cur_y >= screen_rows()) cur_y = screen_rows() - 1;
  endfunction

  // returns 1 when the screen moved up one row
  function automatic bit line_feed();
    int unsigned cols;
    int unsigned rows;
    int unsigned dst;
    cols = screen_cols();
    rows = screen_rows();
    cur_x = 0;
    cur_y++;
    if (cur_y < rows) return 1'b0;
    cur_y = rows - 1;
    if (rows <= 1) return 1'b0;
    for (int unsigned r = 0; r + 1 < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        dst = r * MAX_COLS + c;
        code_mem[dst] = code_mem[dst + MAX_COLS];
        fg_mem[dst]   = fg_mem[dst + MAX_COLS];
        bg_mem[dst]   = bg_mem[dst + MAX_COLS];
      end
    end
    for (int unsigned c = 0; c < cols; c++) put_cell(c, rows - 1, BLANK_CODE, pen_fg, pen_bg);
    return 1'b1;
  endfunction

  function automatic out_item_t run_terminal_action(in_item_t it);
    out_item_t   rep;
    int unsigned cols;
    int unsigned rows;
    int unsigned idx;
    bit          in_screen;
    cols      = screen_cols();
    rows      = screen_rows();
    in_screen = (32'(it.column) < cols) && (32'(it.line) < rows);
    rep       = '0;
    fit_cursor();
    case (it.action)
      ACT_PUT: begin
        rep.in_range = 1'b1;
        if (it.char_code == NL_CODE) begin
          rep.scrolled = line_feed();
        end else if (it.char_code == BS_CODE) begin
          if (cur_x > 0) begin
            cur_x--;
            put_cell(cur_x, cur_y, BLANK_CODE, pen_fg, pen_bg);
          end
        end else if (it.char_code >= PRINT_LO && it.char_code <= PRINT_HI) begin
          put_cell(cur_x, cur_y, it.char_code, pen_fg, pen_bg);
          cur_x++;
          if (cur_x >= cols) rep.scrolled = line_feed();
        end
      end
      ACT_WRITE: begin
        rep.in_range = in_screen;
        if (in_screen) begin
          put_cell(32'(it.column), 32'(it.line), it.char_code, it.cell_fg, it.cell_bg);
        end
      end
      ACT_SETCUR: begin
        rep.in_range = in_screen;
        cur_x = (32'(it.column) >= cols) ? cols - 1 : 32'(it.column);
        cur_y = (32'(it.line) >= rows) ? rows - 1 : 32'(it.line);
      end
      ACT_CLEAR: begin
        blank_everything();
        cur_x = 0;
        cur_y = 0;
      end
      ACT_READ: begin
        if (in_screen) begin
          idx = 32'(it.line) * MAX_COLS + 32'(it.column);
          rep.in_range  = 1'b1;
          rep.read_code = code_mem[idx];
          rep.read_fg   = fg_mem[idx];
          rep.read_bg   = bg_mem[idx];
        end
      end
      default: ;
    endcase
    rep.cursor_column = cur_x[6:0];
    rep.cursor_line   = cur_y[5:0];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pen_fg   = RESET_FG;
      pen_bg   = RESET_BG;
      cols_reg = RESET_COLS;
      rows_reg = RESET_ROWS;
      blank_everything();
      cur_x = 0;
      cur_y = 0;
      awaited_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEXT_FG: pen_fg = cfg_wdata;
          REG_TEXT_BG: pen_bg = cfg_wdata;
          REG_COLS: begin
            cols_reg = cfg_wdata[7:0];
            fit_cursor();
          end
          REG_ROWS: begin
            rows_reg = cfg_wdata[6:0];
            fit_cursor();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited_replies.push_back(run_terminal_action(in_data));
      if (out_valid && out_ready) begin
        n_seen++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: result with nothing expected, got 0x%0h", $time, out_data);
          n_fail++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("cursor_column", 32'(want.cursor_column), 32'(out_data.cursor_column));
          check_field("cursor_line", 32'(want.cursor_line), 32'(out_data.cursor_line));
          check_field("scrolled", 32'(want.scrolled), 32'(out_data.scrolled));
          check_field("in_range", 32'(want.in_range), 32'(out_data.in_range));
          check_field("read_code", 32'(want.read_code), 32'(out_data.read_code));
          check_field("read_fg", want.read_fg, out_data.read_fg);
          check_field("read_bg", want.read_bg, out_data.read_bg);
          if (want.scrolled) n_scroll++;
        end
      end
    end
    n_waiting = awaited_replies.size();
  end

endmodule

### tb/tb.sv
module tb;
  import ttcb_pkg::*;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 64;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int PHASES       = 17;
  localparam int PHASE_ITEMS  = 50;
  localparam int CLEAR_CAP    = 12;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    replies_waiting;
  int                    replies_seen;
  int                    scroll_count;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  int                    clears_sent = 0;
  int                    actions_sent = 0;
  int                    settings_used = 1;

  ttcb_stream_if #(.T(in_item_t))  in_chan ();
  ttcb_stream_if #(.T(out_item_t)) out_chan ();

  text_terminal_cell_buffer #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ttcb_reply_checker #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_data        (in_chan.data),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_data       (out_chan.data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .replies_waiting(replies_waiting),
    .replies_seen   (replies_seen),
    .scroll_count   (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time, replies_waiting);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern: modes held for a random stretch
  initial begin
    int mode;
    int hold;
    out_chan.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      hold = $urandom_range(10, 80);
      repeat (hold) begin
        @(negedge clk);
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 1) == 0);
          2: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= ((cycle_count % 7) > 2);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(logic [2:0] act, logic [7:0] code, logic [7:0] x,
                                         logic [7:0] y, logic [31:0] fg, logic [31:0] bg);
    in_item_t it;
    it.action    = act;
    it.char_code = code;
    it.column    = x;
    it.line      = y;
    it.cell_fg   = fg;
    it.cell_bg   = bg;
    return it;
  endfunction

  function automatic int unsigned fit_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic in_item_t random_action(int unsigned cols, int unsigned rows);
    in_item_t    it;
    int unsigned pick;
    int unsigned sub;
    it = make_item(ACT_PUT, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                   $urandom(), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      sub = $urandom_range(0, 99);
      if (sub < 70) it.char_code = 8'($urandom_range(PRINT_LO, PRINT_HI));
      else if (sub < 82) it.char_code = NL_CODE;
      else if (sub < 92) it.char_code = BS_CODE;
      else if ($urandom_range(0, 1) == 0) it.char_code = 8'($urandom_range(128, 255));
      else it.char_code = 8'($urandom_range(0, PRINT_LO - 1));
    end else if (pick < 94) begin
      if (pick < 63) it.action = ACT_WRITE;
      else if (pick < 75) it.action = ACT_SETCUR;
      else it.action = ACT_READ;
      sub = $urandom_range(0, 9);
      if (sub < 8) begin
        it.column = 8'($urandom_range(0, cols - 1));
        it.line   = 8'(($urandom_range(0, 9) < 3) ? rows - 1 : $urandom_range(0, rows - 1));
      end else if (sub == 8) begin
        it.column = 8'(($urandom_range(0, 1) == 0) ? cols : cols - 1);
        it.line   = 8'(($urandom_range(0, 1) == 0) ? rows : rows - 1);
      end
    end else if (pick < 97) begin
      it.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end else if (clears_sent < CLEAR_CAP) begin
      it.action = ACT_CLEAR;
      clears_sent++;
    end else begin
      it.action = ACT_READ;
    end
    return it;
  endfunction

  task automatic send_action(input in_item_t item);
    int gap;
    in_chan.data  <= item;
    in_chan.valid <= 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    actions_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (replies_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [7:0]  cv;
    logic [6:0]  rv;
    logic [31:0] fgv;
    logic [31:0] bgv;
    int          n;
    int unsigned cols_now;
    int unsigned rows_now;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset screen of 80 by 25
    send_action(make_item(ACT_READ, 0, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, 8'h41, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, PRINT_LO, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, PRINT_HI, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, 8'd128, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, 8'd255, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, 8'd0, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, BS_CODE, 0, 0, 0, 0));
    send_action(make_item(ACT_SETCUR, 0, 8'd0, 8'd3, 0, 0));
    send_action(make_item(ACT_PUT, BS_CODE, 0, 0, 0, 0));
    send_action(make_item(ACT_WRITE, 8'd0, 8'd79, 8'd24, '1, '1));
    send_action(make_item(ACT_WRITE, 8'h58, 8'd80, 8'd0, '1, '0));
    send_action(make_item(ACT_WRITE, 8'd255, 8'd255, 8'd255, '0, '1));
    send_action(make_item(ACT_READ, 0, 8'd79, 8'd24, 0, 0));
    send_action(make_item(ACT_READ, 0, 8'd80, 8'd24, 0, 0));
    send_action(make_item(ACT_READ, 0, 8'd255, 8'd255, 0, 0));
    send_action(make_item(ACT_SETCUR, 0, 8'd200, 8'd100, 0, 0));
    send_action(make_item(ACT_PUT, 8'h5A, 0, 0, 0, 0));
    send_action(make_item(ACT_PUT, NL_CODE, 0, 0, 0, 0));
    send_action(make_item(ACT_SETCUR, 0, 8'd0, 8'd0, 0, 0));
    send_action(make_item(ACT_READ, 0, 8'd79, 8'd22, 0, 0));
    send_action(make_item(ACT_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, '1, '1));
    send_action(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
    send_action(make_item(ACT_READ, 0, 0, 0, 0, 0));
    clears_sent++;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      n   = PHASE_ITEMS;
      fgv = $urandom();
      bgv = $urandom();
      case (p)
        0: begin
          cv  = 8'd255;
          rv  = 7'd127;
          fgv = '1;
          bgv = '1;
          n   = 25;
        end
        1: begin
          cv  = 8'd0;
          rv  = 7'd0;
          fgv = '0;
          bgv = '0;
        end
        2: begin
          cv = 8'(MAX_COLS);
          rv = 7'd1;
        end
        3: begin
          cv = 8'd1;
          rv = 7'(MAX_ROWS);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            cv = 8'($urandom_range(0, 255));
            rv = 7'($urandom_range(0, 4));
          end else begin
            cv = 8'($urandom_range(1, 20));
            rv = 7'($urandom_range(1, 10));
          end
        end
      endcase
      write_reg(REG_TEXT_FG, fgv);
      write_reg(REG_TEXT_BG, bgv);
      write_reg(REG_COLS, {24'd0, cv});
      write_reg(REG_ROWS, {25'd0, rv});
      settings_used++;
      cols_now = fit_dim(32'(cv), MAX_COLS);
      rows_now = fit_dim(32'(rv), MAX_ROWS);
      repeat (n) send_action(random_action(cols_now, rows_now));
      settle();
    end

    $display("%0d actions sent over %0d screen settings, %0d results checked",
             actions_sent, settings_used, replies_seen);
    $display("%0d scrolls and %0d full clears among them", scroll_count, clears_sent);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
